// ----- rtl/core/round_robin_task_scheduler_macros.svh -----
// Assertion macros for the round-robin task scheduler.
// Used by the top level only; needs nothing else.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rrts_pkg.sv -----
// Shared codes, state and command types of the round-robin task scheduler.
// No dependencies.
package rrts_pkg;

    // Request kinds.
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_SPAWN = 3'd1;
    localparam logic [2:0] KIND_YIELD = 3'd2;
    localparam logic [2:0] KIND_SLEEP = 3'd3;
    localparam logic [2:0] KIND_EXIT  = 3'd4;
    localparam logic [2:0] KIND_KILL  = 3'd5;

    // Result status codes.
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_INVALID   = 3'd1;
    localparam logic [2:0] STS_NO_SPACE  = 3'd2;
    localparam logic [2:0] STS_NOT_FOUND = 3'd3;
    localparam logic [2:0] STS_DENIED    = 3'd4;

    // Slot states.
    localparam logic [2:0] SLOT_FREE     = 3'd0;
    localparam logic [2:0] SLOT_READY    = 3'd1;
    localparam logic [2:0] SLOT_RUNNING  = 3'd2;
    localparam logic [2:0] SLOT_SLEEPING = 3'd3;
    localparam logic [2:0] SLOT_ZOMBIE   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_PSTART,
        S_PICK,
        S_FIND,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_START,
        CMD_EXEC,
        CMD_SWEEP,
        CMD_LAST,
        CMD_PSTART,
        CMD_PNEXT,
        CMD_PHIT,
        CMD_NOPICK,
        CMD_ADVANCE,
        CMD_KILL,
        CMD_NOTFOUND
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic load;
    } t_ctl;

    typedef struct packed {
        logic walk_end;
        logic ready_here;
        logic wrap_stop;
        logic id_hit;
    } t_dp_status;

endpackage

// ----- rtl/core/rrts_req_if.sv -----
// Request channel of the round-robin task scheduler.
// No dependencies.
interface rrts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic        entry_present;
    logic        protect_flag;
    logic [31:0] sleep_ticks;
    logic [15:0] target_id;

    modport source (output valid, kind, entry_present, protect_flag, sleep_ticks,
                    target_id, input ready);
    modport sink (input valid, kind, entry_present, protect_flag, sleep_ticks,
                  target_id, output ready);
endinterface

// ----- rtl/core/rrts_rsp_if.sv -----
// Result channel of the round-robin task scheduler.
// No dependencies.
interface rrts_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] task_id;
    logic        run_valid;
    logic [4:0]  live_tasks;

    modport source (output valid, status, task_id, run_valid, live_tasks, input ready);
    modport sink (input valid, status, task_id, run_valid, live_tasks, output ready);
endinterface

// ----- rtl/core/rrts_ctrl.sv -----
// Sequencing state machine of the round-robin task scheduler.
// Depends on rrts_pkg; drives the datapath through rrts_pkg::t_ctl.
module rrts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic [2:0]          i_kind,
    input  rrts_pkg::t_dp_status i_dp,
    input  logic                i_out_free,
    output logic                o_req_ready,
    output rrts_pkg::t_ctl      o_ctl
);

    rrts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_ctl.cmd   = rrts_pkg::CMD_NONE;
        o_ctl.load  = 1'b0;
        case (r_state)
            rrts_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctl.cmd = rrts_pkg::CMD_START;
                    if (i_kind == rrts_pkg::KIND_TICK) begin
                        n_state = rrts_pkg::S_SWEEP;
                    end else if (i_kind == rrts_pkg::KIND_KILL) begin
                        n_state = rrts_pkg::S_FIND;
                    end else begin
                        n_state = rrts_pkg::S_EXEC;
                    end
                end
            end
            rrts_pkg::S_EXEC: begin
                o_ctl.cmd = rrts_pkg::CMD_EXEC;
                n_state   = rrts_pkg::S_DONE;
            end
            rrts_pkg::S_SWEEP: begin
                if (i_dp.walk_end) begin
                    o_ctl.cmd = rrts_pkg::CMD_LAST;
                    n_state   = rrts_pkg::S_PSTART;
                end else begin
                    o_ctl.cmd = rrts_pkg::CMD_SWEEP;
                end
            end
            rrts_pkg::S_PSTART: begin
                o_ctl.cmd = rrts_pkg::CMD_PSTART;
                n_state   = rrts_pkg::S_PICK;
            end
            rrts_pkg::S_PICK: begin
                if (i_dp.walk_end) begin
                    o_ctl.cmd = rrts_pkg::CMD_NOPICK;
                    n_state   = rrts_pkg::S_DONE;
                end else if (i_dp.ready_here) begin
                    o_ctl.cmd = rrts_pkg::CMD_PHIT;
                    n_state   = rrts_pkg::S_DONE;
                end else if (i_dp.wrap_stop) begin
                    o_ctl.cmd = rrts_pkg::CMD_NOPICK;
                    n_state   = rrts_pkg::S_DONE;
                end else begin
                    o_ctl.cmd = rrts_pkg::CMD_PNEXT;
                end
            end
            rrts_pkg::S_FIND: begin
                if (i_dp.walk_end) begin
                    o_ctl.cmd = rrts_pkg::CMD_NOTFOUND;
                    n_state   = rrts_pkg::S_DONE;
                end else if (i_dp.id_hit) begin
                    o_ctl.cmd = rrts_pkg::CMD_KILL;
                    n_state   = rrts_pkg::S_DONE;
                end else begin
                    o_ctl.cmd = rrts_pkg::CMD_ADVANCE;
                end
            end
            rrts_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_ctl.load = 1'b1;
                    n_state    = rrts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/rrts_dp.sv -----
// Task table, list pointers and walk registers of the round-robin task scheduler.
// Depends on rrts_pkg; commanded by rrts_ctrl.
module rrts_dp #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrts_pkg::t_cmd       i_cmd,
    input  logic [2:0]           i_kind,
    input  logic                 i_entry_present,
    input  logic                 i_protect_flag,
    input  logic [31:0]          i_sleep_ticks,
    input  logic [15:0]          i_target_id,
    output rrts_pkg::t_dp_status o_dp,
    output logic [2:0]           o_status,
    output logic [15:0]          o_task_id,
    output logic                 o_run_valid,
    output logic [4:0]           o_live_tasks
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PW = $clog2(MAX_SLOTS + 1);
    localparam logic [PW-1:0] NONE = PW'(MAX_SLOTS);

    // Task table.
    logic [2:0]    r_slot_st   [MAX_SLOTS];
    logic [31:0]   r_slot_wake [MAX_SLOTS];
    logic [15:0]   r_slot_id   [MAX_SLOTS];
    logic          r_slot_prot [MAX_SLOTS];
    logic [PW-1:0] r_slot_succ [MAX_SLOTS];

    logic [PW-1:0] r_head, r_tail, r_last, r_total;
    logic [IW-1:0] r_cur;
    logic [15:0]   r_next_id;
    logic [31:0]   r_tick;

    // Walk registers.
    logic [PW-1:0] r_ptr, r_prev, r_start, r_cnt;

    // Latched request.
    logic [2:0]  r_kind;
    logic        r_entry, r_prot;
    logic [31:0] r_ticks;
    logic [15:0] r_target;

    // Result.
    logic [2:0]  r_status;
    logic [15:0] r_id;
    logic        r_runv;

    logic          ptr_ok;
    logic [IW-1:0] pi;
    logic [2:0]    ptr_st;
    logic [PW-1:0] ptr_succ, wrap_nt, last_succ, pick_start;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic          cur_live;

    assign ptr_ok   = r_ptr < NONE;
    assign pi       = r_ptr[IW-1:0];
    assign ptr_st   = r_slot_st[pi];
    assign ptr_succ = r_slot_succ[pi];
    assign wrap_nt  = (ptr_succ >= NONE) ? r_head : ptr_succ;
    assign last_succ  = ptr_ok ? ptr_succ : NONE;
    assign pick_start = (last_succ < NONE) ? last_succ : r_head;
    assign cur_live = (r_slot_st[r_cur] != rrts_pkg::SLOT_FREE) &&
                      (r_slot_st[r_cur] != rrts_pkg::SLOT_ZOMBIE);

    assign o_dp.walk_end   = !ptr_ok || (r_cnt >= NONE);
    assign o_dp.ready_here = ptr_ok && (ptr_st == rrts_pkg::SLOT_READY);
    assign o_dp.wrap_stop  = (wrap_nt >= NONE) || (wrap_nt == r_start) ||
                             ((r_cnt + PW'(1)) >= NONE);
    assign o_dp.id_hit     = ptr_ok && (r_slot_id[pi] == r_target);

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_st[i] == rrts_pkg::SLOT_FREE) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // Wake times hold no reset; they are read only for sleeping slots.
    always_ff @(posedge i_clk) begin
        if (i_cmd == rrts_pkg::CMD_EXEC && r_kind == rrts_pkg::KIND_SLEEP && cur_live) begin
            r_slot_wake[r_cur] <= r_tick + r_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_slot_st[i]   <= rrts_pkg::SLOT_FREE;
                r_slot_id[i]   <= '0;
                r_slot_prot[i] <= 1'b0;
                r_slot_succ[i] <= NONE;
            end
            r_slot_st[0]   <= rrts_pkg::SLOT_READY;
            r_slot_prot[0] <= 1'b1;
            r_head    <= '0;
            r_tail    <= '0;
            r_last    <= '0;
            r_cur     <= '0;
            r_next_id <= 16'd1;
            r_total   <= PW'(1);
            r_tick    <= '0;
            r_ptr     <= '0;
            r_prev    <= NONE;
            r_start   <= '0;
            r_cnt     <= '0;
            r_status  <= rrts_pkg::STS_OK;
            r_id      <= '0;
            r_runv    <= 1'b0;
        end else begin
            case (i_cmd)
                rrts_pkg::CMD_START: begin
                    r_kind   <= i_kind;
                    r_entry  <= i_entry_present;
                    r_prot   <= i_protect_flag;
                    r_ticks  <= i_sleep_ticks;
                    r_target <= i_target_id;
                    r_ptr    <= r_head;
                    r_prev   <= NONE;
                    r_cnt    <= '0;
                    r_status <= rrts_pkg::STS_OK;
                    r_id     <= '0;
                    r_runv   <= 1'b0;
                    if (i_kind == rrts_pkg::KIND_TICK) begin
                        r_tick <= r_tick + 32'd1;
                    end
                end
                rrts_pkg::CMD_EXEC: begin
                    if (r_kind == rrts_pkg::KIND_SPAWN) begin
                        if (!r_entry) begin
                            r_status <= rrts_pkg::STS_INVALID;
                        end else if (r_total >= NONE || !free_found) begin
                            r_status <= rrts_pkg::STS_NO_SPACE;
                        end else begin
                            r_slot_st[free_idx]   <= rrts_pkg::SLOT_READY;
                            r_slot_id[free_idx]   <= r_next_id;
                            r_slot_prot[free_idx] <= r_prot;
                            r_slot_succ[free_idx] <= NONE;
                            r_id      <= r_next_id;
                            r_next_id <= r_next_id + 16'd1;
                            if (r_head >= NONE) begin
                                r_head <= PW'(free_idx);
                            end else begin
                                r_slot_succ[r_tail[IW-1:0]] <= PW'(free_idx);
                            end
                            r_tail  <= PW'(free_idx);
                            r_total <= r_total + PW'(1);
                        end
                    end else if (r_kind == rrts_pkg::KIND_YIELD ||
                                 r_kind == rrts_pkg::KIND_SLEEP ||
                                 r_kind == rrts_pkg::KIND_EXIT) begin
                        if (!cur_live) begin
                            r_status <= rrts_pkg::STS_NOT_FOUND;
                        end else begin
                            if (r_kind == rrts_pkg::KIND_YIELD) begin
                                r_slot_st[r_cur] <= rrts_pkg::SLOT_READY;
                            end else if (r_kind == rrts_pkg::KIND_SLEEP) begin
                                r_slot_st[r_cur] <= rrts_pkg::SLOT_SLEEPING;
                            end else begin
                                r_slot_st[r_cur] <= rrts_pkg::SLOT_ZOMBIE;
                            end
                            r_cur <= '0;
                        end
                    end else begin
                        r_status <= rrts_pkg::STS_INVALID;
                    end
                end
                rrts_pkg::CMD_SWEEP: begin
                    // Unlink zombies and wake due sleepers in one pass.
                    if (ptr_st == rrts_pkg::SLOT_ZOMBIE) begin
                        if (r_prev < NONE) begin
                            r_slot_succ[r_prev[IW-1:0]] <= ptr_succ;
                        end else begin
                            r_head <= ptr_succ;
                        end
                        if (ptr_succ >= NONE) begin
                            r_tail <= r_prev;
                        end
                        if (r_last == r_ptr) begin
                            r_last <= NONE;
                        end
                        if (r_total != '0) begin
                            r_total <= r_total - PW'(1);
                        end
                        r_slot_st[pi] <= rrts_pkg::SLOT_FREE;
                    end else begin
                        if (ptr_st == rrts_pkg::SLOT_SLEEPING && r_slot_wake[pi] <= r_tick) begin
                            r_slot_st[pi] <= rrts_pkg::SLOT_READY;
                        end
                        r_prev <= r_ptr;
                    end
                    r_ptr <= ptr_succ;
                    r_cnt <= r_cnt + PW'(1);
                end
                rrts_pkg::CMD_LAST: begin
                    r_ptr <= r_last;
                end
                rrts_pkg::CMD_PSTART: begin
                    r_ptr   <= pick_start;
                    r_start <= pick_start;
                    r_cnt   <= '0;
                end
                rrts_pkg::CMD_PNEXT: begin
                    r_ptr <= wrap_nt;
                    r_cnt <= r_cnt + PW'(1);
                end
                rrts_pkg::CMD_PHIT: begin
                    r_slot_st[pi] <= rrts_pkg::SLOT_RUNNING;
                    r_last <= r_ptr;
                    r_cur  <= pi;
                    r_runv <= 1'b1;
                    r_id   <= r_slot_id[pi];
                end
                rrts_pkg::CMD_NOPICK: begin
                    r_runv <= 1'b0;
                end
                rrts_pkg::CMD_ADVANCE: begin
                    r_ptr <= ptr_succ;
                    r_cnt <= r_cnt + PW'(1);
                end
                rrts_pkg::CMD_KILL: begin
                    if (r_slot_prot[pi] || pi == r_cur) begin
                        r_status <= rrts_pkg::STS_DENIED;
                    end else begin
                        r_slot_st[pi] <= rrts_pkg::SLOT_ZOMBIE;
                    end
                end
                rrts_pkg::CMD_NOTFOUND: begin
                    r_status <= rrts_pkg::STS_NOT_FOUND;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status     = r_status;
    assign o_task_id    = r_id;
    assign o_run_valid  = r_runv;
    assign o_live_tasks = 5'(r_total);

endmodule

// ----- rtl/core/round_robin_task_scheduler.sv -----
// Round-robin task scheduler: a cooperative task table with a list in spawn order.
// A request is latched when taken and its result leaves through a one-deep output
// register. Spawn, yield, sleep, exit and unknown kinds pass through the execute state
// and then the done state, which waits for room in the output register. Kill walks the
// task list one slot per cycle until the target id matches or the list ends. Tick makes
// one pass over the list that frees exited tasks and wakes due sleepers, takes a step to
// find where the round-robin scan starts, then scans one slot per cycle until a ready
// task is found or the scan comes back round. A new request is taken as soon as the
// previous one has been handed to the output register, even while that result still
// waits to be taken. There are no configuration registers.
// Depends on rrts_pkg, rrts_req_if, rrts_rsp_if, rrts_ctrl, rrts_dp and the macro header.
`include "round_robin_task_scheduler_macros.svh"

module round_robin_task_scheduler #(
    parameter int MAX_SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rrts_req_if.sink  i_req,
    rrts_rsp_if.source o_rsp
);

    rrts_pkg::t_ctl       ctl;
    rrts_pkg::t_dp_status dp_sts;
    logic                 out_free;
    logic [2:0]           dp_status;
    logic [15:0]          dp_task_id;
    logic                 dp_run_valid;
    logic [4:0]           dp_live;

    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [15:0] r_out_task_id;
    logic        r_out_run_valid;
    logic [4:0]  r_out_live;

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || o_rsp.ready;

    rrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_kind      (i_req.kind),
        .i_dp        (dp_sts),
        .i_out_free  (out_free),
        .o_req_ready (i_req.ready),
        .o_ctl       (ctl)
    );

    rrts_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl.cmd),
        .i_kind          (i_req.kind),
        .i_entry_present (i_req.entry_present),
        .i_protect_flag  (i_req.protect_flag),
        .i_sleep_ticks   (i_req.sleep_ticks),
        .i_target_id     (i_req.target_id),
        .o_dp            (dp_sts),
        .o_status        (dp_status),
        .o_task_id       (dp_task_id),
        .o_run_valid     (dp_run_valid),
        .o_live_tasks    (dp_live)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_out_status    <= dp_status;
            r_out_task_id   <= dp_task_id;
            r_out_run_valid <= dp_run_valid;
            r_out_live      <= dp_live;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.task_id    = r_out_task_id;
    assign o_rsp.run_valid  = r_out_run_valid;
    assign o_rsp.live_tasks = r_out_live;

    // A waiting result is never overwritten.
    `RRTS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_rsp.ready, !ctl.load, "result overwritten while waiting")
    // A loaded result is presented on the next cycle.
    `RRTS_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, ctl.load, o_rsp.valid, "loaded result not presented")
    // After a request is taken the block is busy with it.
    `RRTS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready, "request taken while busy")

endmodule

// ----- dv/rrts_checker.sv -----
// Request/result checker for the round-robin task scheduler testbench.
// Depends on rrts_pkg and the rrts_req_if / rrts_rsp_if interfaces.
module rrts_checker #(
    parameter int MAX_SLOTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rrts_req_if  req,
    rrts_rsp_if  rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_requests,
    output int   o_picks
);
    import rrts_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] task_id;
        logic        run_valid;
        logic [4:0]  live_tasks;
    } t_result;

    localparam int NO_SLOT = MAX_SLOTS;

    // Shadow copy of the task table.
    logic [31:0] now_ticks;
    logic [2:0]  slot_state [MAX_SLOTS];
    logic [31:0] wake_at    [MAX_SLOTS];
    logic [15:0] slot_id    [MAX_SLOTS];
    logic        slot_guard [MAX_SLOTS];
    int          succ       [MAX_SLOTS];
    int          head_slot, prev_pick, running_slot, task_count;
    logic [15:0] id_counter;
    t_result     awaited_results[$];

    function automatic void clear_table();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_state[i] = SLOT_FREE;
            wake_at[i]    = '0;
            slot_id[i]    = '0;
            slot_guard[i] = 1'b0;
            succ[i]       = NO_SLOT;
        end
        slot_state[0] = SLOT_READY;
        slot_guard[0] = 1'b1;
        now_ticks = '0;
        head_slot = 0;
        prev_pick = 0;
        running_slot = 0;
        id_counter = 16'd1;
        task_count = 1;
    endfunction

    // Walks the list twice: first drops exited tasks, then wakes due sleepers.
    function automatic void sweep_list();
        int prv, t, n, nx;
        prv = NO_SLOT;
        t = head_slot;
        n = 0;
        while (t < NO_SLOT && n < MAX_SLOTS) begin
            nx = succ[t];
            if (slot_state[t] == SLOT_ZOMBIE) begin
                if (prv < NO_SLOT) succ[prv] = nx;
                else head_slot = nx;
                if (prev_pick == t) prev_pick = NO_SLOT;
                if (task_count > 0) task_count--;
                slot_state[t] = SLOT_FREE;
            end else begin
                prv = t;
            end
            t = nx;
            n++;
        end
        t = head_slot;
        n = 0;
        while (t < NO_SLOT && n < MAX_SLOTS) begin
            if (slot_state[t] == SLOT_SLEEPING && wake_at[t] <= now_ticks)
                slot_state[t] = SLOT_READY;
            t = succ[t];
            n++;
        end
    endfunction

    function automatic int next_ready_slot();
        int start, t;
        start = head_slot;
        if (prev_pick < NO_SLOT && succ[prev_pick] < NO_SLOT) start = succ[prev_pick];
        if (start >= NO_SLOT) return NO_SLOT;
        t = start;
        for (int n = 0; n < MAX_SLOTS; n++) begin
            if (slot_state[t] == SLOT_READY) return t;
            t = succ[t];
            if (t >= NO_SLOT) t = head_slot;
            if (t >= NO_SLOT || t == start) break;
        end
        return NO_SLOT;
    endfunction

    function automatic t_result schedule_request(input logic [2:0] kind, input logic entry,
                                                 input logic guard, input logic [31:0] dly,
                                                 input logic [15:0] target);
        t_result r;
        int cur, s, t, n, k;
        logic live;
        r = '0;
        r.status = STS_OK;
        cur = running_slot;
        live = slot_state[cur] != SLOT_FREE && slot_state[cur] != SLOT_ZOMBIE;
        case (kind)
            KIND_TICK: begin
                now_ticks++;
                sweep_list();
                s = next_ready_slot();
                if (s < NO_SLOT) begin
                    prev_pick = s;
                    running_slot = s;
                    slot_state[s] = SLOT_RUNNING;
                    r.run_valid = 1'b1;
                    r.task_id = slot_id[s];
                end
            end
            KIND_SPAWN: begin
                s = MAX_SLOTS;
                for (int i = MAX_SLOTS - 1; i >= 0; i--)
                    if (slot_state[i] == SLOT_FREE) s = i;
                if (!entry) r.status = STS_INVALID;
                else if (task_count >= MAX_SLOTS || s >= MAX_SLOTS) r.status = STS_NO_SPACE;
                else begin
                    slot_state[s] = SLOT_READY;
                    slot_id[s] = id_counter;
                    slot_guard[s] = guard;
                    succ[s] = NO_SLOT;
                    r.task_id = id_counter;
                    id_counter++;
                    if (head_slot >= NO_SLOT) head_slot = s;
                    else begin
                        t = head_slot;
                        for (n = 0; n < MAX_SLOTS && succ[t] < NO_SLOT; n++) t = succ[t];
                        succ[t] = s;
                    end
                    task_count++;
                end
            end
            KIND_YIELD, KIND_SLEEP, KIND_EXIT: begin
                if (!live) r.status = STS_NOT_FOUND;
                else begin
                    if (kind == KIND_YIELD) slot_state[cur] = SLOT_READY;
                    else if (kind == KIND_SLEEP) begin
                        slot_state[cur] = SLOT_SLEEPING;
                        wake_at[cur] = now_ticks + dly;
                    end else slot_state[cur] = SLOT_ZOMBIE;
                    running_slot = 0;
                end
            end
            KIND_KILL: begin
                k = NO_SLOT;
                t = head_slot;
                n = 0;
                while (t < NO_SLOT && n < MAX_SLOTS && k == NO_SLOT) begin
                    if (slot_id[t] == target) k = t;
                    t = succ[t];
                    n++;
                end
                if (k >= NO_SLOT) r.status = STS_NOT_FOUND;
                else if (slot_guard[k] || k == running_slot) r.status = STS_DENIED;
                else slot_state[k] = SLOT_ZOMBIE;
            end
            default: r.status = STS_INVALID;
        endcase
        r.live_tasks = 5'(task_count);
        return r;
    endfunction

    initial clear_table();

    assign o_pending = awaited_results.size();

    always @(posedge i_clk) begin
        t_result want, got;
        if (!i_rst_n) begin
            clear_table();
            awaited_results.delete();
            o_fail_count <= 0;
            o_requests <= 0;
            o_picks <= 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.status, rsp.task_id, rsp.run_valid, rsp.live_tasks};
                if (awaited_results.size() == 0) begin
                    $error("result with nothing outstanding: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (got != want) begin
                        if (got.status != want.status)
                            $error("status: expected %0d, got %0d", want.status, got.status);
                        if (got.task_id != want.task_id)
                            $error("task_id: expected %0d, got %0d", want.task_id,
                                   got.task_id);
                        if (got.run_valid != want.run_valid)
                            $error("run_valid: expected %0d, got %0d", want.run_valid,
                                   got.run_valid);
                        if (got.live_tasks != want.live_tasks)
                            $error("live_tasks: expected %0d, got %0d", want.live_tasks,
                                   got.live_tasks);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (req.valid && req.ready) begin
                want = schedule_request(req.kind, req.entry_present, req.protect_flag,
                                        req.sleep_ticks, req.target_id);
                awaited_results.push_back(want);
                o_requests <= o_requests + 1;
                if (want.run_valid) o_picks <= o_picks + 1;
            end
        end
    end
endmodule

// ----- dv/tb_top.sv -----
// Top of the round-robin task scheduler testbench: clock, reset, stimulus and verdict.
// Depends on rrts_pkg, the request/result interfaces, rrts_checker and the scheduler.
module tb_top;
    import rrts_pkg::*;

    localparam int N_RANDOM  = 1030;
    localparam int N_QUIET   = 150;   // final stretch with no idling on either side
    localparam int STALL_CAP = 4000;  // cycles with no handshake before giving up

    logic i_clk;
    logic i_rst_n;
    logic quiet;
    int   fail_count, pending, requests, picks;
    int   idle_cycles;
    logic [15:0] spawned_ids;

    rrts_req_if req ();
    rrts_rsp_if rsp ();

    round_robin_task_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    rrts_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .rsp          (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_requests   (requests),
        .o_picks      (picks)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The result side stalls in random bursts until the quiet stretch begins.
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            rsp.ready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
        end else begin
            rsp.ready <= 1'b1;
        end
    end

    // Watchdog: any cycle with a handshake on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_CAP) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Presents one request and holds it until the scheduler takes it. Valid stays
    // high into the next request unless a random gap is inserted first. Ready only
    // moves at rising edges, so it is looked at on the falling edge before the edge
    // that takes the request.
    task automatic send_request(input logic [2:0] kind, input logic entry = 1'b1,
                                input logic guard = 1'b0, input logic [31:0] dly = '0,
                                input logic [15:0] target = '0);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        req.valid         = 1'b1;
        req.kind          = kind;
        req.entry_present = entry;
        req.protect_flag  = guard;
        req.sleep_ticks   = dly;
        req.target_id     = target;
        while (!req.ready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        if (kind == KIND_SPAWN && entry) spawned_ids++;
    endtask

    task automatic random_request();
        int pick;
        logic [31:0] dly;
        logic [15:0] target;
        pick = $urandom_range(0, 99);
        dly = ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(0, 6));
        // Kills mostly aim at ids that are likely still in the table.
        target = ($urandom_range(0, 5) == 0) ? 16'($urandom())
                                             : spawned_ids - 16'($urandom_range(0, 18));
        if (pick < 34)      send_request(KIND_TICK);
        else if (pick < 54) send_request(KIND_SPAWN, $urandom_range(0, 9) != 0,
                                         $urandom_range(0, 3) == 0);
        else if (pick < 65) send_request(KIND_YIELD);
        else if (pick < 77) send_request(KIND_SLEEP, 1'b1, 1'b0, dly);
        else if (pick < 85) send_request(KIND_EXIT);
        else if (pick < 98) send_request(KIND_KILL, 1'b1, 1'b0, '0, target);
        else                send_request(3'($urandom_range(6, 7)), 1'($urandom()),
                                         1'($urandom()), $urandom(), 16'($urandom()));
    endtask

    initial begin
        i_rst_n = 1'b0;
        quiet = 1'b0;
        spawned_ids = '0;
        req.valid = 1'b0;
        req.kind = KIND_TICK;
        req.entry_present = 1'b0;
        req.protect_flag = 1'b0;
        req.sleep_ticks = '0;
        req.target_id = '0;
        rsp.ready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: the special cases first, starting from the reset table.
        send_request(KIND_KILL, 1'b1, 1'b0, '0, 16'd0);        // idle is protected
        send_request(KIND_KILL, 1'b1, 1'b0, '0, 16'hFFFF);     // id not present
        send_request(KIND_SPAWN, 1'b0);                        // no entry routine
        send_request(KIND_SPAWN, 1'b1, 1'b1);
        send_request(KIND_SPAWN);
        send_request(KIND_TICK);
        send_request(KIND_KILL, 1'b1, 1'b0, '0, 16'd2);        // not the current task
        send_request(KIND_SLEEP, 1'b1, 1'b0, 32'hFFFF_FFFF);   // wake time wraps
        send_request(KIND_TICK);
        send_request(KIND_SLEEP, 1'b1, 1'b0, 32'd0);
        send_request(KIND_TICK);
        send_request(KIND_YIELD);
        send_request(KIND_KILL, 1'b1, 1'b0, '0, 16'd1);        // protected task
        send_request(KIND_KILL, 1'b1, 1'b0, '0, 16'd2);
        send_request(KIND_KILL, 1'b1, 1'b0, '0, 16'd2);        // already exited
        // Fill the table to the brim, then one more spawn must find no room.
        repeat (15) send_request(KIND_SPAWN, 1'b1, 1'($urandom()));
        send_request(3'd6, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(3'd7);
        // The picked task exits; the yield that follows falls back to slot 0, the idle task.
        send_request(KIND_TICK);
        send_request(KIND_EXIT);
        send_request(KIND_YIELD);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - N_QUIET) quiet = 1'b1;
            random_request();
        end
        req.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("Ran %0d scheduler requests; %0d ticks picked a task to run.",
                 requests, picks);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- round_robin_task_scheduler.f -----
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_req_if.sv
rtl/core/rrts_rsp_if.sv
rtl/core/rrts_ctrl.sv
rtl/core/rrts_dp.sv
rtl/core/round_robin_task_scheduler.sv
dv/rrts_checker.sv
dv/tb_top.sv
